>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

>>> rtl/h2fg_pkg.sv
// ----------------------------------------------------------------------------
// h2fg_pkg
// Types, codes and constants of the HTTP/2 frame header generator.
// ----------------------------------------------------------------------------
package h2fg_pkg;

    localparam int unsigned DEFAULT_MAX_REQUEST_BYTES = 1048576;
    localparam logic [23:0] MIN_FRAME_SIZE            = 24'd16384;

    typedef enum logic [2:0] {
        MODE_DATA         = 3'd0,
        MODE_HEADERS      = 3'd1,
        MODE_SETTINGS     = 3'd2,
        MODE_SETTINGS_ACK = 3'd3,
        MODE_RST_STREAM   = 3'd4,
        MODE_GOAWAY       = 3'd5,
        MODE_WINDOW       = 3'd6,
        MODE_PING_ACK     = 3'd7
    } mode_t;

    localparam logic [3:0] TYPE_DATA     = 4'd0;
    localparam logic [3:0] TYPE_HEADERS  = 4'd1;
    localparam logic [3:0] TYPE_RST      = 4'd3;
    localparam logic [3:0] TYPE_SETTINGS = 4'd4;
    localparam logic [3:0] TYPE_PING     = 4'd6;
    localparam logic [3:0] TYPE_GOAWAY   = 4'd7;
    localparam logic [3:0] TYPE_WINDOW   = 4'd8;

    localparam logic [7:0] FLAG_NONE        = 8'h00;
    localparam logic [7:0] FLAG_END_STREAM  = 8'h01;
    localparam logic [7:0] FLAG_ACK         = 8'h01;
    localparam logic [7:0] FLAG_END_HEADERS = 8'h04;

    localparam logic [23:0] LEN_FIXED4 = 24'd4;
    localparam logic [23:0] LEN_FIXED8 = 24'd8;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SPLIT = 1'b1
    } state_t;

    typedef struct packed {
        logic [23:0] frame_length;
        logic [3:0]  frame_type;
        logic [7:0]  frame_flags;
        logic [30:0] frame_stream;
        logic [20:0] source_offset;
        logic        from_source;
        logic [63:0] fixed_payload;
        logic        last_of_run;
        logic        too_long;
    } desc_t;

    typedef struct packed {
        logic load_held;
        logic load_single;
        logic load_frag;
        logic busy;
    } cmd_t;

    typedef struct packed {
        logic        slot_free;
        logic        starts_split;
        logic        last_frag;
        logic [23:0] frame_size;
    } status_t;

endpackage

>>> rtl/h2fg_request_if.sv
// ----------------------------------------------------------------------------
// h2fg_request_if
// Frame request channel: valid/ready handshake with request payload.
// ----------------------------------------------------------------------------
interface h2fg_request_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [30:0] stream_number;
    logic [20:0] request_length;
    logic        end_flag;
    logic [63:0] value_word;

    modport source (
        output valid, mode, stream_number, request_length, end_flag, value_word,
        input  ready
    );

    modport sink (
        input  valid, mode, stream_number, request_length, end_flag, value_word,
        output ready
    );
endinterface

>>> rtl/h2fg_descriptor_if.sv
// ----------------------------------------------------------------------------
// h2fg_descriptor_if
// Frame descriptor channel: valid/ready handshake with descriptor payload.
// ----------------------------------------------------------------------------
interface h2fg_descriptor_if;
    logic        valid;
    logic        ready;
    logic [23:0] frame_length;
    logic [3:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [30:0] frame_stream;
    logic [20:0] source_offset;
    logic        from_source;
    logic [63:0] fixed_payload;
    logic        last_of_run;
    logic        too_long;

    modport source (
        output valid, frame_length, frame_type, frame_flags, frame_stream,
               source_offset, from_source, fixed_payload, last_of_run, too_long,
        input  ready
    );

    modport sink (
        input  valid, frame_length, frame_type, frame_flags, frame_stream,
               source_offset, from_source, fixed_payload, last_of_run, too_long,
        output ready
    );
endinterface

>>> rtl/h2fg_ctrl.sv
// ----------------------------------------------------------------------------
// h2fg_ctrl
// Sequencer: takes requests and steps the DATA fragment loop.
// ----------------------------------------------------------------------------
module h2fg_ctrl
    import h2fg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    request_valid,
    output logic    request_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (request_valid && status.slot_free && status.starts_split)
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (status.slot_free && status.last_frag)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        request_ready   = 1'b0;
        cmd.load_held   = 1'b0;
        cmd.load_single = 1'b0;
        cmd.load_frag   = 1'b0;
        cmd.busy        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                request_ready   = status.slot_free;
                cmd.load_held   = request_valid && status.slot_free && status.starts_split;
                cmd.load_single = request_valid && status.slot_free && !status.starts_split;
            end
            ST_SPLIT:
            begin
                cmd.load_frag = status.slot_free;
                cmd.busy      = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/h2fg_datapath.sv
// ----------------------------------------------------------------------------
// h2fg_datapath
// Frame size register, fragment state and the descriptor output register.
// ----------------------------------------------------------------------------
module h2fg_datapath
    import h2fg_pkg::*;
#(
    parameter int unsigned MAX_REQUEST_BYTES = DEFAULT_MAX_REQUEST_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_size_we,
    input  logic [23:0] frame_size_wdata,
    input  logic [2:0]  mode,
    input  logic [30:0] stream_number,
    input  logic [20:0] request_length,
    input  logic        end_flag,
    input  logic [63:0] value_word,
    input  cmd_t        cmd,
    output status_t     status,
    output logic        desc_valid,
    input  logic        desc_ready,
    output desc_t       desc
);

    localparam logic [24:0] MAX_LEN = 25'(MAX_REQUEST_BYTES);

    logic [23:0] frame_size_reg;
    logic [20:0] offset_reg;
    logic [20:0] offset_next;
    logic [20:0] length_reg;
    logic [30:0] stream_reg;
    logic        end_reg;
    logic [5:0]  count_reg;
    logic        valid_reg;
    logic        valid_next;
    desc_t       desc_reg;

    mode_t       req_mode;
    logic        req_too_long;
    desc_t       single_desc;
    desc_t       frag_desc;
    logic [20:0] remain;
    logic        remain_fits;
    logic [23:0] chunk;

    assign req_mode     = mode_t'(mode);
    assign req_too_long = (req_mode == MODE_DATA || req_mode == MODE_HEADERS ||
                           req_mode == MODE_SETTINGS) &&
                          ({4'b0, request_length} > MAX_LEN);

    // Fragment sizing
    assign remain      = length_reg - offset_reg;
    assign remain_fits = {3'b0, remain} <= frame_size_reg;
    assign chunk       = remain_fits ? {3'b0, remain} : frame_size_reg;
    assign offset_next = offset_reg + chunk[20:0];

    always_comb
    begin
        frag_desc               = '0;
        frag_desc.frame_length  = chunk;
        frag_desc.frame_type    = TYPE_DATA;
        frag_desc.frame_flags   = (remain_fits && end_reg) ? FLAG_END_STREAM : FLAG_NONE;
        frag_desc.frame_stream  = stream_reg;
        frag_desc.source_offset = offset_reg;
        frag_desc.from_source   = 1'b1;
        frag_desc.last_of_run   = remain_fits;
    end

    always_comb
    begin
        single_desc             = '0;
        single_desc.last_of_run = 1'b1;
        if (req_too_long)
        begin
            single_desc.too_long = 1'b1;
        end
        else
        begin
            unique case (req_mode)
                MODE_DATA:
                begin
                    // never loaded as a single descriptor
                    single_desc.from_source = 1'b1;
                end
                MODE_HEADERS:
                begin
                    single_desc.frame_length = {3'b0, request_length};
                    single_desc.frame_type   = TYPE_HEADERS;
                    single_desc.frame_flags  = end_flag ? FLAG_END_HEADERS : FLAG_NONE;
                    single_desc.frame_stream = stream_number;
                    single_desc.from_source  = 1'b1;
                end
                MODE_SETTINGS:
                begin
                    single_desc.frame_length = {3'b0, request_length};
                    single_desc.frame_type   = TYPE_SETTINGS;
                    single_desc.from_source  = 1'b1;
                end
                MODE_SETTINGS_ACK:
                begin
                    single_desc.frame_type  = TYPE_SETTINGS;
                    single_desc.frame_flags = FLAG_ACK;
                end
                MODE_RST_STREAM:
                begin
                    single_desc.frame_length  = LEN_FIXED4;
                    single_desc.frame_type    = TYPE_RST;
                    single_desc.frame_stream  = stream_number;
                    single_desc.fixed_payload = {32'b0, value_word[31:0]};
                end
                MODE_GOAWAY:
                begin
                    single_desc.frame_length  = LEN_FIXED8;
                    single_desc.frame_type    = TYPE_GOAWAY;
                    single_desc.fixed_payload = {1'b0, stream_number, value_word[31:0]};
                end
                MODE_WINDOW:
                begin
                    single_desc.frame_length  = LEN_FIXED4;
                    single_desc.frame_type    = TYPE_WINDOW;
                    single_desc.frame_stream  = stream_number;
                    single_desc.fixed_payload = {33'b0, value_word[30:0]};
                end
                MODE_PING_ACK:
                begin
                    single_desc.frame_length  = LEN_FIXED8;
                    single_desc.frame_type    = TYPE_PING;
                    single_desc.frame_flags   = FLAG_ACK;
                    single_desc.fixed_payload = value_word;
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load_single || cmd.load_frag)
        begin
            valid_next = 1'b1;
        end
        else if (desc_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg <= MIN_FRAME_SIZE;
            offset_reg     <= '0;
            length_reg     <= '0;
            stream_reg     <= '0;
            end_reg        <= 1'b0;
            count_reg      <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (frame_size_we)
            begin
                // clamp up to the protocol minimum
                frame_size_reg <= (frame_size_wdata < MIN_FRAME_SIZE) ?
                                  MIN_FRAME_SIZE : frame_size_wdata;
            end
            if (cmd.load_held)
            begin
                offset_reg <= '0;
                length_reg <= request_length;
                stream_reg <= stream_number;
                end_reg    <= end_flag;
                count_reg  <= '0;
            end
            else if (cmd.load_frag)
            begin
                offset_reg <= offset_next;
                count_reg  <= count_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_single)
        begin
            desc_reg <= single_desc;
        end
        else if (cmd.load_frag)
        begin
            desc_reg <= frag_desc;
        end
    end

    assign status.slot_free    = !valid_reg || desc_ready;
    assign status.starts_split = (req_mode == MODE_DATA) && !req_too_long;
    // stop at the final fragment or when the per-request descriptor cap is hit
    assign status.last_frag    = remain_fits || (count_reg == '1);
    assign status.frame_size   = frame_size_reg;

    assign desc_valid = valid_reg;
    assign desc       = desc_reg;

endmodule

>>> rtl/http2_frame_header_generator.sv
// ----------------------------------------------------------------------------
// http2_frame_header_generator
// Turns HTTP/2 frame requests into per-frame header descriptors.
// ----------------------------------------------------------------------------
// Every request except DATA yields one descriptor; a request that exceeds
// MAX_REQUEST_BYTES yields a single error descriptor. A DATA request yields
// N = max(1, ceil(length / frame size)) descriptors, at most 64: the fragment
// loop emits one descriptor per cycle, while the output is not stalled, into
// the single output register, and no new request is taken until it finishes.
// The peer maximum frame size is to be written by the user through
// frame_size_we/frame_size_wdata while the block is idle; the block itself
// does not enforce this. Values below 16384 are stored as 16384.
module http2_frame_header_generator
    import h2fg_pkg::*;
#(
    parameter int unsigned MAX_REQUEST_BYTES = DEFAULT_MAX_REQUEST_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    h2fg_request_if.sink      request,
    h2fg_descriptor_if.source descriptor,
    input  logic              frame_size_we,
    input  logic [23:0]       frame_size_wdata
);

`include "assert_macros.svh"

    cmd_t    cmd;
    status_t status;
    desc_t   desc;

    h2fg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request.valid),
        .request_ready (request.ready),
        .status        (status),
        .cmd           (cmd)
    );

    h2fg_datapath #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .frame_size_we    (frame_size_we),
        .frame_size_wdata (frame_size_wdata),
        .mode             (request.mode),
        .stream_number    (request.stream_number),
        .request_length   (request.request_length),
        .end_flag         (request.end_flag),
        .value_word       (request.value_word),
        .cmd              (cmd),
        .status           (status),
        .desc_valid       (descriptor.valid),
        .desc_ready       (descriptor.ready),
        .desc             (desc)
    );

    assign descriptor.frame_length  = desc.frame_length;
    assign descriptor.frame_type    = desc.frame_type;
    assign descriptor.frame_flags   = desc.frame_flags;
    assign descriptor.frame_stream  = desc.frame_stream;
    assign descriptor.source_offset = desc.source_offset;
    assign descriptor.from_source   = desc.from_source;
    assign descriptor.fixed_payload = desc.fixed_payload;
    assign descriptor.last_of_run   = desc.last_of_run;
    assign descriptor.too_long      = desc.too_long;

    `ASSERT_IMPLIES(a_no_accept_while_split, clk, rst_n, request.valid && request.ready, !cmd.busy)
    `ASSERT_NEXT(a_data_enters_split, clk, rst_n, request.valid && request.ready && status.starts_split, cmd.busy)
    `ASSERT_IMPLIES(a_error_ends_run, clk, rst_n, descriptor.valid && descriptor.too_long, descriptor.last_of_run && !descriptor.from_source)
    `ASSERT_IMPLIES(a_fragment_fits, clk, rst_n, descriptor.valid && descriptor.from_source && (descriptor.frame_type == TYPE_DATA), descriptor.frame_length <= status.frame_size)

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the HTTP/2 frame header generator. Frame requests go in over
// the request channel and descriptors come out of the descriptor channel.
// A model of the generator in this file builds the descriptors that each
// accepted request should produce, and a checker compares every descriptor
// that arrives with the oldest one that is still outstanding. Directed cases
// cover the field extremes, every request mode, fragmentation and the size
// clamp. Random traffic then runs under several peer frame sizes, with random
// idling on both channels, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
    import h2fg_pkg::*;

    localparam int unsigned MAX_REQ        = DEFAULT_MAX_REQUEST_BYTES;
    localparam int unsigned MAX_FRAGMENTS  = 64;
    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam logic [20:0] LEN_ALL_ONES   = 21'h1FFFFF;
    localparam logic [30:0] STREAM_MAX     = 31'h7FFFFFFF;
    localparam logic [63:0] WORD_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        mode_t       mode;
        logic [30:0] stream_number;
        logic [20:0] request_length;
        logic        end_flag;
        logic [63:0] value_word;
    } frame_request_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        frame_size_we;
    logic [23:0] frame_size_wdata;

    h2fg_request_if    req_ch ();
    h2fg_descriptor_if dsc_ch ();

    http2_frame_header_generator #(
        .MAX_REQUEST_BYTES (MAX_REQ)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .request          (req_ch),
        .descriptor       (dsc_ch),
        .frame_size_we    (frame_size_we),
        .frame_size_wdata (frame_size_wdata)
    );

    always #5 clk = ~clk;

    desc_t       pending_frames[$];
    logic [23:0] model_frame_size;
    int unsigned error_count      = 0;
    int unsigned report_count     = 0;
    int unsigned idle_cycles      = 0;
    int unsigned hold_cycles_req  = 0;
    bit          quiet_tail       = 1'b0;

    // ------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------
    function automatic void predict_frames(input frame_request_t r);
        desc_t       d;
        logic [23:0] rem;
        logic [23:0] chunk;
        logic [20:0] offset;
        logic        is_last;
        int unsigned n;
        d = '0;
        d.last_of_run = 1'b1;
        if ((r.mode == MODE_DATA || r.mode == MODE_HEADERS || r.mode == MODE_SETTINGS)
            && r.request_length > MAX_REQ)
        begin
            d.too_long = 1'b1;
            pending_frames.push_back(d);
            return;
        end
        case (r.mode)
            MODE_DATA:
            begin
                offset  = '0;
                is_last = 1'b0;
                n       = 0;
                while (!is_last && n < MAX_FRAGMENTS)
                begin
                    rem     = {3'b000, r.request_length} - {3'b000, offset};
                    chunk   = (rem < model_frame_size) ? rem : model_frame_size;
                    is_last = (chunk == rem);
                    d               = '0;
                    d.frame_length  = chunk;
                    d.frame_type    = TYPE_DATA;
                    d.frame_flags   = (is_last && r.end_flag) ? FLAG_END_STREAM : FLAG_NONE;
                    d.frame_stream  = r.stream_number;
                    d.source_offset = offset;
                    d.from_source   = 1'b1;
                    d.last_of_run   = is_last;
                    pending_frames.push_back(d);
                    offset = offset + chunk[20:0];
                    n++;
                end
            end
            MODE_HEADERS:
            begin
                d.frame_length = {3'b000, r.request_length};
                d.frame_type   = TYPE_HEADERS;
                d.frame_flags  = r.end_flag ? FLAG_END_HEADERS : FLAG_NONE;
                d.frame_stream = r.stream_number;
                d.from_source  = 1'b1;
                pending_frames.push_back(d);
            end
            MODE_SETTINGS:
            begin
                d.frame_length = {3'b000, r.request_length};
                d.frame_type   = TYPE_SETTINGS;
                d.from_source  = 1'b1;
                pending_frames.push_back(d);
            end
            MODE_SETTINGS_ACK:
            begin
                d.frame_type  = TYPE_SETTINGS;
                d.frame_flags = FLAG_ACK;
                pending_frames.push_back(d);
            end
            MODE_RST_STREAM:
            begin
                d.frame_length  = LEN_FIXED4;
                d.frame_type    = TYPE_RST;
                d.frame_stream  = r.stream_number;
                d.fixed_payload = {32'h0, r.value_word[31:0]};
                pending_frames.push_back(d);
            end
            MODE_GOAWAY:
            begin
                d.frame_length  = LEN_FIXED8;
                d.frame_type    = TYPE_GOAWAY;
                d.fixed_payload = {1'b0, r.stream_number, r.value_word[31:0]};
                pending_frames.push_back(d);
            end
            MODE_WINDOW:
            begin
                d.frame_length  = LEN_FIXED4;
                d.frame_type    = TYPE_WINDOW;
                d.frame_stream  = r.stream_number;
                d.fixed_payload = {33'h0, r.value_word[30:0]};
                pending_frames.push_back(d);
            end
            default:
            begin
                d.frame_length  = LEN_FIXED8;
                d.frame_type    = TYPE_PING;
                d.frame_flags   = FLAG_ACK;
                d.fixed_payload = r.value_word;
                pending_frames.push_back(d);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Descriptor checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        desc_t got;
        desc_t want;
        if (rst_n && dsc_ch.valid && dsc_ch.ready)
        begin
            got = '{dsc_ch.frame_length, dsc_ch.frame_type, dsc_ch.frame_flags,
                    dsc_ch.frame_stream, dsc_ch.source_offset, dsc_ch.from_source,
                    dsc_ch.fixed_payload, dsc_ch.last_of_run, dsc_ch.too_long};
            if (pending_frames.size() == 0)
            begin
                error_count++;
                if (report_count < REPORT_LIMIT)
                begin
                    report_count++;
                    $display("unexpected descriptor len=%0d type=%0d flags=%h stream=%h",
                             got.frame_length, got.frame_type, got.frame_flags,
                             got.frame_stream);
                end
            end
            else
            begin
                want = pending_frames.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (report_count < REPORT_LIMIT)
                    begin
                        report_count++;
                        $display("mismatch exp: len=%0d type=%0d flags=%h stream=%h off=%0d",
                                 want.frame_length, want.frame_type, want.frame_flags,
                                 want.frame_stream, want.source_offset);
                        $display("              src=%b fixed=%h last=%b err=%b",
                                 want.from_source, want.fixed_payload, want.last_of_run,
                                 want.too_long);
                        $display("         act: len=%0d type=%0d flags=%h stream=%h off=%0d",
                                 got.frame_length, got.frame_type, got.frame_flags,
                                 got.frame_stream, got.source_offset);
                        $display("              src=%b fixed=%h last=%b err=%b",
                                 got.from_source, got.fixed_payload, got.last_of_run,
                                 got.too_long);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (dsc_ch.valid && dsc_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Descriptor receiver: random stalls, long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned gap;
        dsc_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles_req != 0)
            begin
                gap = hold_cycles_req;
                hold_cycles_req = 0;
                dsc_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 12);
                dsc_ch.ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
            begin
                dsc_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic frame_request_t make_request(input mode_t m, input logic [30:0] s,
                                                    input logic [20:0] len, input logic e,
                                                    input logic [63:0] w);
        frame_request_t r;
        r.mode           = m;
        r.stream_number  = s;
        r.request_length = len;
        r.end_flag       = e;
        r.value_word     = w;
        return r;
    endfunction

    function automatic logic [20:0] random_length();
        longint unsigned v;
        int unsigned     sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            v = 64'($urandom_range(0, 65536));
        else if (sel <= 7)
            v = 64'($urandom_range(0, MAX_REQ));
        else if (sel == 8)
        begin
            // land on or next to a fragment boundary
            v = 64'($urandom_range(1, MAX_FRAGMENTS)) * 64'(model_frame_size)
                + 64'($urandom_range(0, 2));
            v = (v == 64'd0) ? 64'd0 : v - 64'd1;
            if (v > 64'(LEN_ALL_ONES))
                v = 64'(LEN_ALL_ONES);
        end
        else
            v = 64'($urandom_range(0, LEN_ALL_ONES));
        return v[20:0];
    endfunction

    function automatic frame_request_t random_request();
        frame_request_t r;
        r.mode           = mode_t'($urandom_range(0, 7));
        r.stream_number  = 31'($urandom);
        r.request_length = random_length();
        r.end_flag       = 1'($urandom_range(0, 1));
        r.value_word     = {$urandom, $urandom};
        return r;
    endfunction

    // Present one request, hold until the transaction completes; valid stays high.
    task automatic send_request(input frame_request_t r);
        req_ch.valid          <= 1'b1;
        req_ch.mode           <= r.mode;
        req_ch.stream_number  <= r.stream_number;
        req_ch.request_length <= r.request_length;
        req_ch.end_flag       <= r.end_flag;
        req_ch.value_word     <= r.value_word;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predict_frames(r);
    endtask

    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count)
        begin
            send_request(random_request());
            sender_gap();
        end
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_size(input logic [23:0] value);
        wait_drain();
        frame_size_we    <= 1'b1;
        frame_size_wdata <= value;
        @(posedge clk);
        frame_size_we    <= 1'b0;
        model_frame_size = (value < MIN_FRAME_SIZE) ? MIN_FRAME_SIZE : value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_modes_at_reset_size();
        send_request(make_request(MODE_DATA, STREAM_MAX, 21'd0, 1'b1, WORD_ONES));
        send_request(make_request(MODE_DATA, 31'd0, 21'd1, 1'b0, 64'h0));
        send_request(make_request(MODE_DATA, 31'd3, 21'd16384, 1'b1, 64'h0));
        send_request(make_request(MODE_DATA, 31'd5, 21'd16385, 1'b1, 64'h0));
        send_request(make_request(MODE_DATA, 31'd7, 21'(MAX_REQ), 1'b1, 64'h0));
        send_request(make_request(MODE_DATA, 31'd9, 21'(MAX_REQ + 1), 1'b1, WORD_ONES));
        send_request(make_request(MODE_DATA, STREAM_MAX, LEN_ALL_ONES, 1'b1, WORD_ONES));
        send_request(make_request(MODE_HEADERS, 31'd1, 21'(MAX_REQ), 1'b1, 64'h0));
        send_request(make_request(MODE_HEADERS, 31'd0, 21'd0, 1'b0, WORD_ONES));
        send_request(make_request(MODE_HEADERS, STREAM_MAX, 21'(MAX_REQ + 1), 1'b1, 64'h0));
        send_request(make_request(MODE_SETTINGS, STREAM_MAX, 21'd6, 1'b1, WORD_ONES));
        send_request(make_request(MODE_SETTINGS, 31'd0, LEN_ALL_ONES, 1'b0, 64'h0));
        send_request(make_request(MODE_SETTINGS_ACK, STREAM_MAX, LEN_ALL_ONES, 1'b1,
                                  WORD_ONES));
        send_request(make_request(MODE_RST_STREAM, STREAM_MAX, LEN_ALL_ONES, 1'b1,
                                  WORD_ONES));
        send_request(make_request(MODE_RST_STREAM, 31'd0, 21'd0, 1'b0, 64'h0));
        send_request(make_request(MODE_GOAWAY, STREAM_MAX, 21'd0, 1'b1, WORD_ONES));
        send_request(make_request(MODE_GOAWAY, 31'd0, 21'd0, 1'b0,
                                  64'hFFFF_FFFF_0000_0000));
        send_request(make_request(MODE_WINDOW, STREAM_MAX, LEN_ALL_ONES, 1'b1, WORD_ONES));
        send_request(make_request(MODE_WINDOW, 31'd1, 21'd0, 1'b0, 64'h0000_0000_8000_0000));
        send_request(make_request(MODE_PING_ACK, STREAM_MAX, LEN_ALL_ONES, 1'b1, WORD_ONES));
        send_request(make_request(MODE_PING_ACK, 31'd0, 21'd0, 1'b0, 64'h0));
    endtask

    task automatic test_frame_size_clamp();
        set_frame_size(24'd0);
        send_request(make_request(MODE_DATA, 31'd11, 21'd16385, 1'b1, 64'h0));
        set_frame_size(24'd16383);
        send_request(make_request(MODE_DATA, 31'd13, 21'd32768, 1'b1, 64'h0));
        set_frame_size(24'hFFFFFF);
        send_request(make_request(MODE_DATA, 31'd15, 21'(MAX_REQ), 1'b1, 64'h0));
        send_request(make_request(MODE_DATA, 31'd17, LEN_ALL_ONES, 1'b0, 64'h0));
        set_frame_size(24'd16385);
        send_request(make_request(MODE_DATA, 31'd19, 21'd32770, 1'b1, 64'h0));
    endtask

    task automatic test_random_traffic();
        set_frame_size(24'd16384);
        send_random(45);
        set_frame_size(24'($urandom_range(16384, 65536)));
        send_random(45);
        set_frame_size(24'hFFFFFF);
        send_random(35);
        set_frame_size(24'($urandom_range(0, 16383)));
        send_random(25);
        set_frame_size(24'($urandom));
        send_random(25);
    endtask

    task automatic test_output_backpressure();
        set_frame_size(24'd16384);
        hold_cycles_req = HOLD_CYCLES;
        send_random(20);
    endtask

    task automatic test_drain_pause();
        set_frame_size(24'($urandom_range(16384, 200000)));
        send_random(10);
        wait_drain();
        send_random(10);
    endtask

    task automatic test_quiet_tail();
        set_frame_size(24'd16384);
        quiet_tail = 1'b1;
        send_random(40);
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        frame_size_we         <= 1'b0;
        frame_size_wdata      <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.mode           <= MODE_DATA;
        req_ch.stream_number  <= '0;
        req_ch.request_length <= '0;
        req_ch.end_flag       <= 1'b0;
        req_ch.value_word     <= '0;
        model_frame_size      = MIN_FRAME_SIZE;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_modes_at_reset_size();
        test_frame_size_clamp();
        test_random_traffic();
        test_output_backpressure();
        test_drain_pause();
        test_quiet_tail();

        wait_drain();
        repeat (2 * MAX_FRAGMENTS) @(posedge clk);
        if (error_count == 0 && pending_frames.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
